// ===== rtl/cpce_pkg.sv =====
package cpce_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 1;
    localparam int SYM_W     = 16;
    localparam int PIX_W     = 8;
    localparam int SAT_W     = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } t_reg_idx;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_NEXT = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        PH_LOADING,
        PH_SCAN,
        PH_CHAIN
    } t_phase;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HDR_W,
        ST_HDR_H,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_EMIT_X,
        ST_EMIT_Y,
        ST_PIX_RD,
        ST_PIX,
        ST_NBR_RD,
        ST_NBR_CHK,
        ST_DIR,
        ST_TRL_W,
        ST_TRL_H
    } t_state;

    typedef enum logic [2:0] {
        SEL_W,
        SEL_H,
        SEL_X,
        SEL_Y,
        SEL_PIX,
        SEL_DIR
    } t_sym_sel;

    typedef enum logic [1:0] {
        RD_SCAN,
        RD_PIX,
        RD_NBR
    } t_rd_sel;

    typedef struct packed {
        logic     load_en;
        logic     cfg_en;
        logic     hdr_start;
        logic     scan_step;
        logic     re;
        t_rd_sel  rd_sel;
        logic     push;
        t_sym_sel sym_sel;
        logic     eog;
        logic     done;
        logic     d_clr;
        logic     d_inc;
        logic     take_nbr;
        logic     dir_zero;
        logic     link_done;
        logic     restart;
    } t_cmd_bus;

    typedef struct packed {
        t_phase phase;
        logic   full;
        logic   scan_done;
        logic   mark;
        logic   last_row;
        logic   d_last;
        logic   slot_free;
    } t_sts_bus;

endpackage

// ===== rtl/cpce_intf.sv =====
interface cpce_in_if;
    logic                      valid;
    logic                      ready;
    logic                      command;
    logic [cpce_pkg::PIX_W-1:0] pixel;
    modport source (output valid, command, pixel, input ready);
    modport sink (input valid, command, pixel, output ready);
endinterface

interface cpce_out_if;
    logic                       valid;
    logic                       ready;
    logic [cpce_pkg::SYM_W-1:0] symbol;
    logic                       symbol_is_wide;
    logic                       end_of_group;
    logic                       stream_done;
    modport source (output valid, symbol, symbol_is_wide, end_of_group, stream_done,
                    input ready);
    modport sink (input valid, symbol, symbol_is_wide, end_of_group, stream_done,
                  output ready);
endinterface

interface cpce_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [cpce_pkg::CFG_IDX_W-1:0] index;
    logic [cpce_pkg::CFG_W-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/cpce_ram.sv =====
module cpce_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/cpce_ctrl.sv =====
module cpce_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_command,
    input  logic                i_cfg_valid,
    input  cpce_pkg::t_sts_bus  i_sts,
    output logic                o_in_ready,
    output logic                o_cfg_ready,
    output cpce_pkg::t_cmd_bus  o_cmd
);
    cpce_pkg::t_state r_state, n_state;
    logic             in_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cpce_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready  = (r_state == cpce_pkg::ST_IDLE);
    assign o_cfg_ready = (r_state == cpce_pkg::ST_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_cmd.rd_sel    = cpce_pkg::RD_SCAN;
        o_cmd.sym_sel   = cpce_pkg::SEL_W;
        o_cmd.load_en   = in_acc && (i_in_command == cpce_pkg::CMD_LOAD);
        o_cmd.cfg_en    = i_cfg_valid && o_cfg_ready;
        case (r_state)
            cpce_pkg::ST_IDLE: begin
                if (in_acc && (i_in_command == cpce_pkg::CMD_NEXT)) begin
                    case (i_sts.phase)
                        cpce_pkg::PH_LOADING: if (i_sts.full) n_state = cpce_pkg::ST_HDR_W;
                        cpce_pkg::PH_CHAIN:   n_state = cpce_pkg::ST_PIX_RD;
                        default:              n_state = cpce_pkg::ST_SCAN_RD;
                    endcase
                end
            end
            cpce_pkg::ST_HDR_W: begin
                o_cmd.sym_sel = cpce_pkg::SEL_W;
                if (i_sts.slot_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = cpce_pkg::ST_HDR_H;
                end
            end
            cpce_pkg::ST_HDR_H: begin
                o_cmd.sym_sel = cpce_pkg::SEL_H;
                o_cmd.eog     = 1'b1;
                if (i_sts.slot_free) begin
                    o_cmd.push      = 1'b1;
                    o_cmd.hdr_start = 1'b1;
                    n_state         = cpce_pkg::ST_IDLE;
                end
            end
            cpce_pkg::ST_SCAN_RD: begin
                if (i_sts.scan_done) begin
                    n_state = cpce_pkg::ST_TRL_W;
                end else begin
                    o_cmd.re        = 1'b1;
                    o_cmd.rd_sel    = cpce_pkg::RD_SCAN;
                    o_cmd.scan_step = 1'b1;
                    n_state         = cpce_pkg::ST_SCAN_CHK;
                end
            end
            cpce_pkg::ST_SCAN_CHK: begin
                n_state = i_sts.mark ? cpce_pkg::ST_EMIT_X : cpce_pkg::ST_SCAN_RD;
            end
            cpce_pkg::ST_EMIT_X: begin
                o_cmd.sym_sel = cpce_pkg::SEL_X;
                if (i_sts.slot_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = cpce_pkg::ST_EMIT_Y;
                end
            end
            cpce_pkg::ST_EMIT_Y: begin
                o_cmd.sym_sel = cpce_pkg::SEL_Y;
                if (i_sts.slot_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = cpce_pkg::ST_PIX_RD;
                end
            end
            cpce_pkg::ST_PIX_RD: begin
                o_cmd.re     = 1'b1;
                o_cmd.rd_sel = cpce_pkg::RD_PIX;
                n_state      = cpce_pkg::ST_PIX;
            end
            cpce_pkg::ST_PIX: begin
                o_cmd.sym_sel = cpce_pkg::SEL_PIX;
                if (i_sts.slot_free) begin
                    o_cmd.push = 1'b1;
                    if (i_sts.last_row) begin
                        o_cmd.dir_zero = 1'b1;
                        n_state        = cpce_pkg::ST_DIR;
                    end else begin
                        o_cmd.d_clr = 1'b1;
                        n_state     = cpce_pkg::ST_NBR_RD;
                    end
                end
            end
            cpce_pkg::ST_NBR_RD: begin
                o_cmd.re     = 1'b1;
                o_cmd.rd_sel = cpce_pkg::RD_NBR;
                n_state      = cpce_pkg::ST_NBR_CHK;
            end
            cpce_pkg::ST_NBR_CHK: begin
                o_cmd.rd_sel = cpce_pkg::RD_NBR;
                if (i_sts.mark) begin
                    o_cmd.take_nbr = 1'b1;
                    n_state        = cpce_pkg::ST_DIR;
                end else if (i_sts.d_last) begin
                    o_cmd.dir_zero = 1'b1;
                    n_state        = cpce_pkg::ST_DIR;
                end else begin
                    o_cmd.d_inc = 1'b1;
                    n_state     = cpce_pkg::ST_NBR_RD;
                end
            end
            cpce_pkg::ST_DIR: begin
                o_cmd.sym_sel = cpce_pkg::SEL_DIR;
                o_cmd.eog     = 1'b1;
                if (i_sts.slot_free) begin
                    o_cmd.push      = 1'b1;
                    o_cmd.link_done = 1'b1;
                    n_state         = cpce_pkg::ST_IDLE;
                end
            end
            cpce_pkg::ST_TRL_W: begin
                o_cmd.sym_sel = cpce_pkg::SEL_W;
                o_cmd.done    = 1'b1;
                if (i_sts.slot_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = cpce_pkg::ST_TRL_H;
                end
            end
            cpce_pkg::ST_TRL_H: begin
                o_cmd.sym_sel = cpce_pkg::SEL_H;
                o_cmd.done    = 1'b1;
                o_cmd.eog     = 1'b1;
                if (i_sts.slot_free) begin
                    o_cmd.push    = 1'b1;
                    o_cmd.restart = 1'b1;
                    n_state       = cpce_pkg::ST_IDLE;
                end
            end
            default: n_state = cpce_pkg::ST_IDLE;
        endcase
    end
endmodule

// ===== rtl/cpce_dp.sv =====
module cpce_dp #(
    parameter int MAX_WIDTH  = cpce_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = cpce_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  cpce_pkg::t_cmd_bus                i_cmd,
    input  logic [cpce_pkg::PIX_W-1:0]        i_pixel,
    input  logic [cpce_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [cpce_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                              i_out_ready,
    output cpce_pkg::t_sts_bus                o_sts,
    output logic                              o_out_valid,
    output logic [cpce_pkg::SYM_W-1:0]        o_symbol,
    output logic                              o_symbol_is_wide,
    output logic                              o_end_of_group,
    output logic                              o_stream_done
);
    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int WW = XW + 1;
    localparam int HW = YW + 1;
    localparam int AW = XW + YW;
    localparam int MW = cpce_pkg::PIX_W + 1;

    logic [cpce_pkg::CFG_W-1:0] r_cfg_w, r_cfg_h;
    logic [cpce_pkg::PIX_W-1:0] r_prev;
    logic                       r_prev_none;
    logic [XW-1:0]              r_lx, r_sc, r_cx;
    logic [YW-1:0]              r_ly, r_cy;
    logic [HW-1:0]              r_sr;
    logic                       r_full;
    cpce_pkg::t_phase           r_phase;
    logic [1:0]                 r_d;
    logic [1:0]                 r_dir;
    logic                       r_ovalid;
    logic [cpce_pkg::SYM_W-1:0] r_sym;
    logic                       r_wide, r_eog, r_done;

    logic [cpce_pkg::SAT_W-1:0] sat_w, sat_h, c_w, c_h;
    logic [WW-1:0]              eff_w;
    logic [HW-1:0]              eff_h;
    logic [XW-1:0]              nx;
    logic [AW-1:0]              raddr;
    logic [MW-1:0]              rdata;
    logic                       we, lx_end, ly_end;
    logic [cpce_pkg::SYM_W-1:0] sym;

    always_comb begin
        c_w = (r_cfg_w == '0) ? cpce_pkg::SAT_W'(1) : cpce_pkg::SAT_W'(r_cfg_w);
        c_h = (r_cfg_h == '0) ? cpce_pkg::SAT_W'(1) : cpce_pkg::SAT_W'(r_cfg_h);
        sat_w = (c_w > cpce_pkg::SAT_W'(MAX_WIDTH)) ? cpce_pkg::SAT_W'(MAX_WIDTH) : c_w;
        sat_h = (c_h > cpce_pkg::SAT_W'(MAX_HEIGHT)) ? cpce_pkg::SAT_W'(MAX_HEIGHT) : c_h;
    end
    assign eff_w = sat_w[WW-1:0];
    assign eff_h = sat_h[HW-1:0];

    always_comb begin
        case (r_d)
            2'd1:    nx = (r_cx == '0) ? '0 : r_cx - XW'(1);
            2'd2:    nx = ((WW'(r_cx) + WW'(1)) >= eff_w) ? XW'(eff_w - WW'(1))
                                                         : r_cx + XW'(1);
            default: nx = r_cx;
        endcase
    end

    always_comb begin
        case (i_cmd.rd_sel)
            cpce_pkg::RD_PIX: raddr = {r_cy, r_cx};
            cpce_pkg::RD_NBR: raddr = {r_cy + YW'(1), nx};
            default:          raddr = {r_sr[YW-1:0], r_sc};
        endcase
    end

    assign we     = i_cmd.load_en && (r_phase == cpce_pkg::PH_LOADING) && !r_full;
    assign lx_end = (WW'(r_lx) + WW'(1)) == eff_w;
    assign ly_end = (HW'(r_ly) + HW'(1)) == eff_h;

    cpce_ram #(.WIDTH(MW), .DEPTH(1 << AW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr ({r_ly, r_lx}),
        .i_wdata ({r_prev_none || (i_pixel != r_prev), i_pixel}),
        .i_re    (i_cmd.re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        case (i_cmd.sym_sel)
            cpce_pkg::SEL_W:   sym = cpce_pkg::SYM_W'(eff_w);
            cpce_pkg::SEL_H:   sym = cpce_pkg::SYM_W'(eff_h);
            cpce_pkg::SEL_X:   sym = cpce_pkg::SYM_W'(r_cx);
            cpce_pkg::SEL_Y:   sym = cpce_pkg::SYM_W'(r_cy);
            cpce_pkg::SEL_PIX: sym = cpce_pkg::SYM_W'(rdata[cpce_pkg::PIX_W-1:0]);
            default:           sym = cpce_pkg::SYM_W'(r_dir);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w     <= cpce_pkg::CFG_W'(256);
            r_cfg_h     <= cpce_pkg::CFG_W'(256);
            r_prev_none <= 1'b1;
            r_lx        <= '0;
            r_ly        <= '0;
            r_full      <= 1'b0;
            r_phase     <= cpce_pkg::PH_LOADING;
            r_sc        <= '0;
            r_sr        <= '0;
            r_cx        <= '0;
            r_cy        <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            if (i_out_ready) r_ovalid <= 1'b0;
            if (i_cmd.push) begin
                r_ovalid <= 1'b1;
                r_sym    <= sym;
                r_wide   <= (i_cmd.sym_sel != cpce_pkg::SEL_PIX) &&
                            (i_cmd.sym_sel != cpce_pkg::SEL_DIR);
                r_eog    <= i_cmd.eog;
                r_done   <= i_cmd.done;
            end
            if (we) begin
                r_prev      <= i_pixel;
                r_prev_none <= 1'b0;
                if (lx_end) begin
                    r_lx <= '0;
                    if (ly_end) r_full <= 1'b1;
                    else        r_ly   <= r_ly + YW'(1);
                end else begin
                    r_lx <= r_lx + XW'(1);
                end
            end
            if (i_cmd.hdr_start) begin
                r_sc    <= '0;
                r_sr    <= '0;
                r_phase <= cpce_pkg::PH_SCAN;
            end
            if (i_cmd.scan_step) begin
                r_cx <= r_sc;
                r_cy <= r_sr[YW-1:0];
                if ((WW'(r_sc) + WW'(1)) >= eff_w) begin
                    r_sc <= '0;
                    r_sr <= r_sr + HW'(1);
                end else begin
                    r_sc <= r_sc + XW'(1);
                end
            end
            if (i_cmd.d_clr) r_d <= 2'd0;
            if (i_cmd.d_inc) r_d <= r_d + 2'd1;
            if (i_cmd.dir_zero) r_dir <= 2'd0;
            if (i_cmd.take_nbr) begin
                r_dir <= r_d + 2'd1;
                r_cx  <= nx;
                r_cy  <= r_cy + YW'(1);
            end
            if (i_cmd.link_done) begin
                r_phase <= (r_dir != 2'd0) ? cpce_pkg::PH_CHAIN : cpce_pkg::PH_SCAN;
            end
            if (i_cmd.restart || i_cmd.cfg_en) begin
                r_phase     <= cpce_pkg::PH_LOADING;
                r_full      <= 1'b0;
                r_lx        <= '0;
                r_ly        <= '0;
                r_prev_none <= 1'b1;
            end
            if (i_cmd.cfg_en) begin
                if (i_cfg_index == cpce_pkg::REG_WIDTH) r_cfg_w <= i_cfg_data;
                else                                    r_cfg_h <= i_cfg_data;
            end
        end
    end

    assign o_sts.phase     = r_phase;
    assign o_sts.full      = r_full;
    assign o_sts.scan_done = (r_sr == eff_h);
    assign o_sts.mark      = rdata[cpce_pkg::PIX_W];
    assign o_sts.last_row  = (HW'(r_cy) + HW'(1)) >= eff_h;
    assign o_sts.d_last    = (r_d == 2'd2);
    assign o_sts.slot_free = !r_ovalid || i_out_ready;

    assign o_out_valid      = r_ovalid;
    assign o_symbol         = r_sym;
    assign o_symbol_is_wide = r_wide;
    assign o_end_of_group   = r_eog;
    assign o_stream_done    = r_done;
endmodule

// ===== rtl/change_point_chain_encoder.sv =====
// Change-point chain encoder. Loads (command 0) are taken one per cycle while the block is
// idle and, while the frame is still loading, store each pixel with its change mark in one
// frame memory. A next command (command 1) yields one symbol group: header, a marked
// pixel's x, y, pixel and direction, a further chain link, or the trailer; before the
// frame is full it yields nothing. The block takes no new item until the group has been
// handed to its output register. A group steps through one state per symbol pushed, a
// memory read and a mark check per raster position scanned to find the next mark, a read
// before the pixel symbol and a read and a check per neighbor probed (at most three); each
// push waits until the output register is free. Scans and probes split read and check as
// the one read port has a registered output. Width and height writes restart loading.
module change_point_chain_encoder #(
    parameter int MAX_WIDTH  = cpce_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = cpce_pkg::DEF_MAX_HEIGHT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cpce_in_if.sink    i_in,
    cpce_cfg_if.sink   i_cfg,
    cpce_out_if.source o_out
);
    cpce_pkg::t_cmd_bus cmd;
    cpce_pkg::t_sts_bus sts;

    cpce_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in.valid),
        .i_in_command (i_in.command),
        .i_cfg_valid  (i_cfg.valid),
        .i_sts        (sts),
        .o_in_ready   (i_in.ready),
        .o_cfg_ready  (i_cfg.ready),
        .o_cmd        (cmd)
    );

    cpce_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_pixel          (i_in.pixel),
        .i_cfg_index      (i_cfg.index),
        .i_cfg_data       (i_cfg.data),
        .i_out_ready      (o_out.ready),
        .o_sts            (sts),
        .o_out_valid      (o_out.valid),
        .o_symbol         (o_out.symbol),
        .o_symbol_is_wide (o_out.symbol_is_wide),
        .o_end_of_group   (o_out.end_of_group),
        .o_stream_done    (o_out.stream_done)
    );

    a_push_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.push |-> sts.slot_free) else $error("push into occupied output register");

    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.cfg_en |=> (sts.phase == cpce_pkg::PH_LOADING) && !sts.full)
        else $error("config write did not restart loading");

    a_done_wide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.stream_done) |-> o_out.symbol_is_wide)
        else $error("trailer symbol not wide");
endmodule

// ===== test/cpce_checker.sv =====
`timescale 1ns / 100ps
module cpce_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    cpce_in_if   in_ch,
    cpce_cfg_if  cfg_ch,
    cpce_out_if  out_ch,
    output logic o_image_open,
    output int   o_pending,
    output int   o_errors
);
    import cpce_pkg::*;

    localparam int MW = DEF_MAX_WIDTH;
    localparam int MH = DEF_MAX_HEIGHT;

    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic             wide;
        logic             eog;
        logic             done;
    } t_sym_rec;

    t_sym_rec         sym_q[$];
    logic [PIX_W-1:0] pix_mem[MW*MH];
    bit               mark_mem[MW*MH];
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [8:0]       last_pix;
    int               loaded;
    int               scan_x;
    int               scan_y;
    int               link_x;
    int               link_y;
    t_phase           phase;
    int               errors;

    function automatic int w_eff();
        if (width_reg == 0) return 1;
        if (width_reg > MW) return MW;
        return width_reg;
    endfunction

    function automatic int h_eff();
        if (height_reg == 0) return 1;
        if (height_reg > MH) return MH;
        return height_reg;
    endfunction

    function automatic int addr(int x, int y);
        return (y * MW + x) % (MW * MH);
    endfunction

    task automatic push_sym(int s, logic wide, logic eog, logic done);
        sym_q.push_back('{s[SYM_W-1:0], wide, eog, done});
    endtask

    task automatic restart_image();
        phase    = PH_LOADING;
        loaded   = 0;
        last_pix = 9'h100;
    endtask

    task automatic emit_link(int x, int y, output int dir);
        int nx;
        dir = 0;
        push_sym(pix_mem[addr(x, y)], 1'b0, 1'b0, 1'b0);
        if (y + 1 < h_eff()) begin
            for (int d = 0; d < 3; d++) begin
                nx = x;
                if (d == 1) nx = (x == 0) ? 0 : x - 1;
                if (d == 2) nx = (x + 1 >= w_eff()) ? w_eff() - 1 : x + 1;
                if (dir == 0 && mark_mem[addr(nx, y + 1)]) begin
                    dir    = d + 1;
                    link_x = nx;
                    link_y = y + 1;
                end
            end
        end
        push_sym(dir, 1'b0, 1'b1, 1'b0);
    endtask

    task automatic predict_next();
        int  w;
        int  h;
        int  x;
        int  y;
        int  dir;
        bit  found;
        w = w_eff();
        h = h_eff();
        if (phase == PH_LOADING) begin
            if (loaded < w * h) return;
            push_sym(w, 1'b1, 1'b0, 1'b0);
            push_sym(h, 1'b1, 1'b1, 1'b0);
            scan_x = 0;
            scan_y = 0;
            phase  = PH_SCAN;
            return;
        end
        if (phase == PH_CHAIN) begin
            emit_link(link_x, link_y, dir);
            if (dir == 0) phase = PH_SCAN;
            return;
        end
        found = 0;
        while (!found && scan_y < h) begin
            x = scan_x;
            y = scan_y;
            scan_x++;
            if (scan_x >= w) begin
                scan_x = 0;
                scan_y++;
            end
            if (x < w && mark_mem[addr(x, y)]) begin
                found = 1;
                push_sym(x, 1'b1, 1'b0, 1'b0);
                push_sym(y, 1'b1, 1'b0, 1'b0);
                emit_link(x, y, dir);
                if (dir != 0) phase = PH_CHAIN;
            end
        end
        if (!found) begin
            push_sym(w, 1'b1, 1'b0, 1'b1);
            push_sym(h, 1'b1, 1'b1, 1'b1);
            restart_image();
        end
    endtask

    task automatic load_pixel(logic [PIX_W-1:0] p);
        int w;
        w = w_eff();
        if (phase == PH_LOADING && loaded < w * h_eff()) begin
            pix_mem[addr(loaded % w, loaded / w)]  = p;
            mark_mem[addr(loaded % w, loaded / w)] = ({1'b0, p} != last_pix);
            last_pix = {1'b0, p};
            loaded++;
        end
    endtask

    task automatic check_symbol();
        t_sym_rec got;
        t_sym_rec want;
        got = '{out_ch.symbol, out_ch.symbol_is_wide, out_ch.end_of_group,
                out_ch.stream_done};
        if (sym_q.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected symbol %h wide %b eog %b done %b",
                         got.sym, got.wide, got.eog, got.done);
        end else begin
            want = sym_q.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10)
                    $display("symbol mismatch: exp %h/%b/%b/%b got %h/%b/%b/%b",
                             want.sym, want.wide, want.eog, want.done,
                             got.sym, got.wide, got.eog, got.done);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sym_q.delete();
            width_reg  = CFG_W'(MW);
            height_reg = CFG_W'(MH);
            scan_x     = 0;
            scan_y     = 0;
            link_x     = 0;
            link_y     = 0;
            errors     = 0;
            restart_image();
        end else begin
            if (out_ch.valid && out_ch.ready) check_symbol();
            if (cfg_ch.valid && cfg_ch.ready) begin
                if (t_reg_idx'(cfg_ch.index) == REG_WIDTH) width_reg = cfg_ch.data;
                else height_reg = cfg_ch.data;
                restart_image();
            end
            if (in_ch.valid && in_ch.ready) begin
                if (t_cmd'(in_ch.command) == CMD_LOAD) load_pixel(in_ch.pixel);
                else predict_next();
            end
        end
        o_image_open <= (phase != PH_LOADING) || (loaded == w_eff() * h_eff());
        o_pending    <= sym_q.size();
        o_errors     <= errors;
    end
endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
module tb;
    import cpce_pkg::*;

    localparam int LIMIT = 600000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #4 i_clk = ~i_clk;

    cpce_in_if  in_ch ();
    cpce_cfg_if cfg_ch ();
    cpce_out_if out_ch ();

    change_point_chain_encoder uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    logic image_open;
    int   pending;
    int   errors;

    cpce_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .cfg_ch       (cfg_ch),
        .out_ch       (out_ch),
        .o_image_open (image_open),
        .o_pending    (pending),
        .o_errors     (errors)
    );

    int         cycles = 0;
    int         items = 0;
    int         burst_left = 0;
    int         hold_ask = 0;
    int         hold_done = 0;
    int         hold_cnt = 0;
    int         rx_mode = 0;
    logic [7:0] last_pix = 8'd0;

    initial begin
        in_ch.valid    = 1'b0;
        in_ch.command  = CMD_LOAD;
        in_ch.pixel    = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = REG_WIDTH;
        cfg_ch.data    = '0;
        out_ch.ready   = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("change_point_chain_encoder regression: fail");
            $finish;
        end
    end

    // receiver: long hold on request, otherwise a stall pattern that changes now and then
    always @(posedge i_clk) begin
        if (cycles % 64 == 0) rx_mode <= $urandom_range(0, 2);
        if (hold_cnt > 0) begin
            out_ch.ready <= 1'b0;
            hold_cnt     <= hold_cnt - 1;
        end else if (hold_done != hold_ask) begin
            hold_done    <= hold_ask;
            hold_cnt     <= 400;
            out_ch.ready <= 1'b0;
        end else begin
            case (rx_mode)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= $urandom_range(0, 1);
                default: out_ch.ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    function automatic int sat(int v, int max_v);
        if (v == 0) return 1;
        if (v > max_v) return max_v;
        return v;
    endfunction

    function automatic logic [7:0] pick_pixel();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) return last_pix;
        if (r < 50) return 8'd0;
        if (r < 65) return 8'd255;
        return 8'($urandom);
    endfunction

    task automatic send(t_cmd c, logic [7:0] p);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_ch.valid   <= 1'b1;
        in_ch.command <= c;
        in_ch.pixel   <= p;
        if (c == CMD_LOAD) last_pix = p;
        do @(posedge i_clk); while (!in_ch.ready);
        items++;
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_reg_idx r, logic [8:0] v);
        in_ch.valid  <= 1'b0;
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= r;
        cfg_ch.data  <= v;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain(bit noisy, bit hold);
        send(CMD_NEXT, 8'($urandom));
        if (hold) hold_ask++;
        while (image_open) begin
            if (noisy && $urandom_range(0, 9) == 0) send(CMD_LOAD, 8'($urandom));
            else send(CMD_NEXT, 8'($urandom));
        end
    endtask

    task automatic run_image(logic [8:0] wr, logic [8:0] hr, bit hold);
        int total;
        int stop_at;
        settle();
        cfg_write(REG_WIDTH, wr);
        cfg_write(REG_HEIGHT, hr);
        total = sat(wr, DEF_MAX_WIDTH) * sat(hr, DEF_MAX_HEIGHT);
        if (total > 1 && $urandom_range(0, 9) == 0) begin
            stop_at = $urandom_range(1, total - 1);
            for (int i = 0; i < stop_at; i++) send(CMD_LOAD, pick_pixel());
            settle();
            cfg_write(REG_HEIGHT, hr);
        end
        for (int i = 0; i < total; i++) begin
            if ($urandom_range(0, 19) == 0) send(CMD_NEXT, 8'($urandom));
            send(CMD_LOAD, pick_pixel());
        end
        if ($urandom_range(0, 4) == 0) send(CMD_LOAD, 8'($urandom));
        drain(1'b1, hold);
    endtask

    initial begin
        logic [7:0] grid[9] = '{8'd1, 8'd2, 8'd2, 8'd2, 8'd9, 8'd9, 8'd3, 8'd3, 8'd9};
        int img;
        logic [8:0] wr;
        logic [8:0] hr;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // one-pixel image from zero register values, with early and late nexts
        send(CMD_NEXT, 8'd0);
        cfg_write(REG_WIDTH, 9'd0);
        cfg_write(REG_HEIGHT, 9'd0);
        send(CMD_LOAD, 8'd255);
        send(CMD_LOAD, 8'd7);
        drain(1'b0, 1'b0);
        send(CMD_NEXT, 8'd0);
        settle();

        // 3x3 image with chains going down, down-left and down-right
        cfg_write(REG_WIDTH, 9'd3);
        cfg_write(REG_HEIGHT, 9'd3);
        foreach (grid[i]) send(CMD_LOAD, grid[i]);
        send(CMD_NEXT, 8'd0);
        send(CMD_LOAD, 8'd0);
        drain(1'b0, 1'b0);

        img = 0;
        while (items < 90) begin
            case (img)
                2: begin wr = 9'd1; hr = 9'd5; end
                4: begin wr = 9'd6; hr = 9'd1; end
                default: begin
                    wr = $urandom_range(1, 6);
                    hr = $urandom_range(1, 5);
                end
            endcase
            run_image(wr, hr, img == 1);
            img++;
        end
        settle();
        if (errors == 0 && pending == 0)
            $display("change_point_chain_encoder regression: pass");
        else
            $display("change_point_chain_encoder regression: fail");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/cpce_pkg.sv
rtl/cpce_intf.sv
rtl/cpce_ram.sv
rtl/cpce_ctrl.sv
rtl/cpce_dp.sv
rtl/change_point_chain_encoder.sv
test/cpce_checker.sv
test/tb.sv
